/* rtl/lmsb_pkg.sv */
// Shared types and constants for the LED matrix scan and blink core.
`timescale 1ns / 1ps

package lmsb_pkg;

    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_MASK = 2'd1,
        OP_VOLT = 2'd2,
        OP_TAG  = 2'd3
    } op_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_FIRST_BIT = 2'd1;

    localparam logic [15:0] BLINK_PERIOD_RESET = 16'd300;

    localparam logic [1:0] STATE_OFF   = 2'd0;
    localparam logic [1:0] STATE_ON    = 2'd1;
    localparam logic [1:0] STATE_BLINK = 2'd2;

    localparam int OUT_ROWS = 8;
    localparam int OUT_COLS = 3;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] now_ms;
        logic [31:0] func_mask;
        logic [1:0]  new_state;
        logic [7:0]  volt_bits;
        logic [4:0]  led_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] row_drive;
        logic [2:0] col_drive_n;
    } out_item_t;

    typedef struct packed {
        logic       set_en;
        logic [1:0] set_state;
        logic       tag_wr;
        logic [4:0] led_index;
    } lmsb_cmd_t;

endpackage

/* rtl/lmsb_led_array.sv */
// Per-LED state and tag registers with parallel tag match and one row read port.
`timescale 1ns / 1ps

module lmsb_led_array import lmsb_pkg::*; #(
    parameter int ROWS      = 8,
    parameter int COLS      = 3,
    parameter int TAG_WIDTH = 32,
    parameter int ROW_W     = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lmsb_cmd_t                 cmd,
    input  logic [TAG_WIDTH-1:0]      mask,
    input  logic [TAG_WIDTH-1:0]      tag_data,
    input  logic [ROW_W-1:0]          rd_row,
    output logic [COLS-1:0][1:0]      rd_state
);

    localparam int NUM_LEDS = ROWS * COLS;

    logic [COLS-1:0][1:0]  state_reg [ROWS];
    logic [TAG_WIDTH-1:0]  tag_reg   [NUM_LEDS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                state_reg[r] <= '0;
            end
        end else if (cmd.set_en) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    if (|(tag_reg[r*COLS + c] & mask)) begin
                        state_reg[r][c] <= cmd.set_state;
                    end
                end
            end
        end
    end

    // tags hold no reset value; out-of-range indexes match no entry
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            if (cmd.tag_wr && (int'(cmd.led_index) == i)) begin
                tag_reg[i] <= tag_data;
            end
        end
    end

    assign rd_state = state_reg[rd_row];

endmodule

/* rtl/led_matrix_scan_blink_core.sv */
// Top level of the LED matrix scan and blink core.
`timescale 1ns / 1ps

// Drives a ROWS x COLS LED matrix one row per scan beat. Each input beat is
// captured in an input register and executed from it; a scan beat's result is
// then registered in the output register. One beat is accepted per clock while
// no scan beat stalls; the single execute stage sets the rate and stalls
// a scan beat only while a result waits in the output register. Mask and voltage
// beats update every LED whose tag matches in parallel; tag writes load one
// LED's tag and must precede any use of that tag. The blink phase flips on a
// scan beat whose time is more than blink_period_ms past the last flip.
// Configuration writes are always accepted and take effect at once.
module led_matrix_scan_blink_core import lmsb_pkg::*; #(
    parameter int ROWS      = 8,
    parameter int COLS      = 3,
    parameter int TAG_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FM_W  = (TAG_WIDTH > 32) ? TAG_WIDTH : 32;
    localparam int SH_W  = (TAG_WIDTH > 40) ? TAG_WIDTH : 40;

    logic                 in_valid_reg, in_valid_next;
    in_item_t             in_item_reg;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;
    logic [15:0]          period_reg;
    logic [4:0]           vfb_reg;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 phase_reg, phase_next;
    logic [31:0]          last_ms_reg, last_ms_next;

    logic                 exec;
    logic                 is_scan;
    logic                 flip;
    logic [31:0]          elapsed;
    logic [FM_W-1:0]      fm_wide;
    logic [SH_W-1:0]      volt_wide;
    logic [TAG_WIDTH-1:0] mask;
    lmsb_cmd_t            cmd;
    logic [COLS-1:0][1:0] rd_state;
    logic [OUT_COLS-1:0]  col_n;

    assign is_scan = (in_item_reg.opcode == OP_SCAN);
    assign exec    = in_valid_reg && (!is_scan || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;
    assign cfg_ready = 1'b1;

    // blink timer
    assign elapsed    = in_item_reg.now_ms - last_ms_reg;
    assign flip       = elapsed > {16'b0, period_reg};
    assign phase_next = (exec && is_scan && flip) ? !phase_reg : phase_reg;
    assign last_ms_next = (exec && is_scan && flip) ? in_item_reg.now_ms : last_ms_reg;

    // match masks
    assign fm_wide   = FM_W'(in_item_reg.func_mask);
    assign volt_wide = SH_W'(in_item_reg.volt_bits) << vfb_reg;
    assign mask      = (in_item_reg.opcode == OP_VOLT) ? volt_wide[TAG_WIDTH-1:0]
                                                       : fm_wide[TAG_WIDTH-1:0];

    always_comb begin
        cmd.set_en    = exec && ((in_item_reg.opcode == OP_MASK) ||
                                 (in_item_reg.opcode == OP_VOLT));
        cmd.set_state = (in_item_reg.opcode == OP_VOLT) ? STATE_ON : in_item_reg.new_state;
        cmd.tag_wr    = exec && (in_item_reg.opcode == OP_TAG);
        cmd.led_index = in_item_reg.led_index;
    end

    lmsb_led_array #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .TAG_WIDTH (TAG_WIDTH),
        .ROW_W     (ROW_W)
    ) u_array (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .mask     (mask),
        .tag_data (fm_wide[TAG_WIDTH-1:0]),
        .rd_row   (row_reg),
        .rd_state (rd_state)
    );

    // column drives, active low; columns beyond COLS read zero
    for (genvar c = 0; c < OUT_COLS; c++) begin : g_col
        if (c < COLS) begin : g_used
            assign col_n[c] = !((rd_state[c] == STATE_ON) ||
                                ((rd_state[c] == STATE_BLINK) && phase_next));
        end else begin : g_unused
            assign col_n[c] = 1'b0;
        end
    end

    always_comb begin
        for (int b = 0; b < OUT_ROWS; b++) begin
            m_item_next.row_drive[b] = (b < ROWS) && (int'(row_reg) == b);
        end
        m_item_next.col_drive_n = col_n;

        if (exec && is_scan) begin
            row_next = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
        end else begin
            row_next = row_reg;
        end

        if (exec && is_scan) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            row_reg      <= '0;
            phase_reg    <= 1'b0;
            last_ms_reg  <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            row_reg      <= row_next;
            phase_reg    <= phase_next;
            last_ms_reg  <= last_ms_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (exec && is_scan) begin
            m_item_reg <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= BLINK_PERIOD_RESET;
            vfb_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BLINK_PERIOD:   period_reg <= cfg_data;
                CFG_VOLT_FIRST_BIT: vfb_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* rtl/lmsb_checker.sv */
// Port-level checks for the LED matrix scan and blink core, bound to the top level.
`timescale 1ns / 1ps

module lmsb_checker import lmsb_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // at most one row is driven in any valid result
    a_row_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_item.row_drive))
        else $error("more than one row driven");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back pressure");

endmodule

bind led_matrix_scan_blink_core lmsb_checker u_lmsb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
